@@ src/b128h_pkg.sv @@
// types, constants and command codes shared by the binary128 hypotenuse block
`default_nettype none
package b128h_pkg;

  localparam int RW    = 340;  // radicand register width
  localparam int RH    = RW / 2;  // root width, one bit per digit pair
  localparam int RMW   = RH + 3;  // partial remainder width
  localparam int SW    = 169;  // aligned significand width
  localparam int NBITS = 230;  // minimum radicand length for the root

  localparam logic [63:0] EXP_HI   = 64'h7fff000000000000;
  localparam logic [63:0] QUIET_HI = 64'h0000800000000000;

  typedef struct packed {
    logic [63:0] x_hi;
    logic [63:0] x_lo;
    logic [63:0] y_hi;
    logic [63:0] y_lo;
  } req_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MULA, S_MULB, S_NORM, S_ROOT, S_QINIT, S_RND, S_FIN, S_DONE
  } state_e;

  typedef enum logic [3:0] {
    C_NONE, C_LOAD, C_MSTEP, C_MULB, C_NORM, C_RINIT, C_RSTEP, C_QINIT, C_QSTEP, C_FIN
  } cmd_e;

  typedef struct packed {
    logic early;
    logic mr_zero;
    logic norm_ok;
    logic root_last;
    logic sh_done;
  } stat_t;

endpackage
`default_nettype wire

@@ src/binary128_hypot.sv @@
// top level of the correctly rounded binary128 hypotenuse unit
// channel  | ports                  | handshake
// request  | start, data_i          | taken when start && !busy
// result   | done_o, result_o       | one-cycle strobe, cannot be held off
// one request at a time; special operands, a zero operand or a wide gap strobe
// the result in the cycle after the request; otherwise the run time is
// set by the serial squaring (one multiplier bit per cycle, both operands),
// the normalization (one digit pair per cycle), the 170-bit root
// and the rounding shift (one bit per cycle, up to 114 bits)
// reset clears the controller only; no clearing pass
`default_nettype none
module binary128_hypot (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire b128h_pkg::req_t data_i,
  output logic                 busy,
  output logic                 done_o,
  output b128h_pkg::res_t      result_o
);
  import b128h_pkg::*;

  cmd_e  cmd;
  stat_t stat;

  b128h_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  b128h_dp u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .data_i   (data_i),
    .stat_o   (stat),
    .result_o (result_o)
  );

endmodule
`default_nettype wire

@@ src/b128h_dp.sv @@
// datapath: operand setup, serial squaring, normalization, bitwise root, rounding
`default_nettype none
module b128h_dp (
  input  wire logic          clk_i,
  input  wire b128h_pkg::cmd_e  cmd_i,
  input  wire b128h_pkg::req_t  data_i,
  output b128h_pkg::stat_t      stat_o,
  output b128h_pkg::res_t       result_o
);
  import b128h_pkg::*;

  function automatic logic is_snan(logic [63:0] hi, logic [63:0] lo);
    logic above;
    above = (hi > EXP_HI) || (hi == EXP_HI && lo != 64'd0);
    return above && !hi[47];
  endfunction

  logic [RW-1:0]  v_q, md_q;
  logic [SW-1:0]  mr_q;
  logic [112:0]   mb_q;
  logic signed [17:0] eb_q;
  logic [6:0]     k_q;
  logic [RMW-1:0] rem_q;
  logic [RH-1:0]  res_q;
  logic [7:0]     n_q, cnt_q, sh_q;
  logic           g_q, st_q, ovf_q, nrm_q;
  logic [14:0]    expo_q;
  res_t           out_q;

  // operand ordering and special cases
  logic [63:0] ph, qh, ah, al, bh, bl;
  logic        p_ge, gap;
  logic [14:0] exa, exb;
  logic signed [17:0] ea, eb, dn;
  logic [112:0] ma, mb;
  logic [SW-1:0] sa;
  res_t         early_res;
  logic         early;

  assign ph   = {1'b0, data_i.x_hi[62:0]};
  assign qh   = {1'b0, data_i.y_hi[62:0]};
  assign p_ge = {ph, data_i.x_lo} >= {qh, data_i.y_lo};
  assign ah   = p_ge ? ph : qh;
  assign al   = p_ge ? data_i.x_lo : data_i.y_lo;
  assign bh   = p_ge ? qh : ph;
  assign bl   = p_ge ? data_i.y_lo : data_i.x_lo;
  assign exa  = ah[62:48];
  assign exb  = bh[62:48];
  assign ea   = (exa != 15'd0) ? $signed({3'b000, exa}) - 18'sd16383 : -18'sd16382;
  assign eb   = (exb != 15'd0) ? $signed({3'b000, exb}) - 18'sd16383 : -18'sd16382;
  assign dn   = ea - eb;
  assign gap  = dn > 18'sd56;
  assign ma   = {exa != 15'd0, ah[47:0], al};
  assign mb   = {exb != 15'd0, bh[47:0], bl};
  assign sa   = SW'(ma) << dn[5:0];

  always_comb begin
    early     = 1'b1;
    early_res = '{result_hi: ah, result_lo: al};
    if (ah >= EXP_HI) begin
      if (is_snan(ah, al) || is_snan(bh, bl)) begin
        early_res = '{result_hi: EXP_HI | QUIET_HI, result_lo: 64'd0};
      end else if ((ah == EXP_HI && al == 64'd0) || (bh == EXP_HI && bl == 64'd0)) begin
        early_res = '{result_hi: EXP_HI, result_lo: 64'd0};
      end
    end else if (!(bh == 64'd0 && bl == 64'd0) && !gap) begin
      early = 1'b0;
    end
  end

  // root step
  logic [RMW-1:0] rem_sh, trial;
  logic           ge;
  assign rem_sh = {rem_q[RMW-3:0], v_q[RW-1:RW-2]};
  assign trial  = RMW'({res_q, 2'b01});
  assign ge     = rem_sh >= trial;

  // rounding setup
  logic signed [17:0] e0, e, shf;
  assign e0  = eb_q - 18'sd112 - $signed({11'd0, k_q});
  assign e   = e0 + $signed({10'd0, n_q}) - 18'sd1;
  assign shf = (e >= -18'sd16382) ? $signed({10'd0, n_q}) - 18'sd113 : -18'sd16494 - e0;

  logic         up;
  logic [127:0] qv;
  assign up = g_q && (st_q || res_q[0]);
  always_comb begin
    qv = res_q[127:0] + 128'(up);
    if (nrm_q) qv = qv + {1'b0, expo_q, 112'd0};
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      C_LOAD: begin
        out_q   <= early_res;
        md_q    <= RW'(sa);
        mr_q    <= sa;
        v_q     <= '0;
        mb_q    <= mb;
        eb_q    <= eb;
        k_q     <= '0;
      end
      C_MSTEP: begin
        if (mr_q[0]) v_q <= v_q + md_q;
        md_q <= md_q << 1;
        mr_q <= mr_q >> 1;
      end
      C_MULB: begin
        md_q <= RW'(mb_q);
        mr_q <= SW'(mb_q);
      end
      C_NORM: begin
        v_q <= v_q << 2;
        k_q <= k_q + 7'd1;
      end
      C_RINIT: begin
        rem_q <= '0;
        res_q <= '0;
        n_q   <= '0;
        cnt_q <= '0;
      end
      C_RSTEP: begin
        v_q   <= v_q << 2;
        rem_q <= ge ? rem_sh - trial : rem_sh;
        res_q <= {res_q[RH-2:0], ge};
        if (res_q != '0 || ge) n_q <= n_q + 8'd1;
        cnt_q <= cnt_q + 8'd1;
      end
      C_QINIT: begin
        ovf_q  <= e > 18'sd16383;
        nrm_q  <= e >= -18'sd16382;
        expo_q <= 15'(e + 18'sd16382);
        g_q    <= 1'b0;
        st_q   <= rem_q != '0;
        if (shf < 18'sd1) sh_q <= 8'd1;
        else if (shf > 18'sd255) sh_q <= 8'd255;
        else sh_q <= shf[7:0];
      end
      C_QSTEP: begin
        st_q  <= st_q | g_q;
        g_q   <= res_q[0];
        res_q <= res_q >> 1;
        sh_q  <= sh_q - 8'd1;
      end
      C_FIN: begin
        if (ovf_q) out_q <= '{result_hi: EXP_HI, result_lo: 64'd0};
        else out_q <= '{result_hi: qv[127:64], result_lo: qv[63:0]};
      end
      default: begin
      end
    endcase
  end

  assign stat_o.early     = early;
  assign stat_o.mr_zero   = mr_q == '0;
  assign stat_o.norm_ok   = v_q[RW-1:NBITS-1] != '0;
  assign stat_o.root_last = cnt_q == 8'(RH - 1);
  assign stat_o.sh_done   = sh_q == 8'd0;
  assign result_o         = out_q;

endmodule
`default_nettype wire

@@ src/b128h_ctrl.sv @@
// controller state machine sequencing the hypotenuse datapath
`default_nettype none
module b128h_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire b128h_pkg::stat_t stat_i,
  output logic                 busy,
  output logic                 done_o,
  output b128h_pkg::cmd_e      cmd_o
);
  import b128h_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = stat_i.early ? S_DONE : S_MULA;
      S_MULA:  if (stat_i.mr_zero) state_d = S_MULB;
      S_MULB:  if (stat_i.mr_zero) state_d = S_NORM;
      S_NORM:  if (stat_i.norm_ok) state_d = S_ROOT;
      S_ROOT:  if (stat_i.root_last) state_d = S_QINIT;
      S_QINIT: state_d = S_RND;
      S_RND:   if (stat_i.sh_done) state_d = S_FIN;
      S_FIN:   state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = C_NONE;
    case (state_q)
      S_IDLE:  if (start) cmd_o = C_LOAD;
      S_MULA:  cmd_o = stat_i.mr_zero ? C_MULB : C_MSTEP;
      S_MULB:  if (!stat_i.mr_zero) cmd_o = C_MSTEP;
      S_NORM:  cmd_o = stat_i.norm_ok ? C_RINIT : C_NORM;
      S_ROOT:  cmd_o = C_RSTEP;
      S_QINIT: cmd_o = C_QINIT;
      S_RND:   if (!stat_i.sh_done) cmd_o = C_QSTEP;
      S_FIN:   cmd_o = C_FIN;
      default: cmd_o = C_NONE;
    endcase
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = state_q == S_DONE;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy)
    else $error("result strobe outside a request");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but not busy");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule
`default_nettype wire

@@ sim/tb_binary128_hypot.sv @@
// self-checking testbench for the binary128 hypotenuse unit with a bit-exact predictor
`default_nettype none
module tb_binary128_hypot;
  timeunit 1ns;
  timeprecision 1ps;
  import b128h_pkg::*;

  localparam int          EXP_MIN    = -16382;
  localparam int          EXP_MAX    = 16383;
  localparam int          GAP_MAX    = 56;
  localparam int          SIG_BITS   = 113;
  localparam int          ROOT_MIN   = 230;
  localparam int          N_RANDOM   = 1330;
  localparam int          QUIET_TAIL = 150;
  localparam int          STALL_MAX  = 5000;
  localparam logic [63:0] SIGN_MASK  = 64'h7fffffffffffffff;
  localparam logic [63:0] FRAC_MASK  = 64'h0000ffffffffffff;

  typedef enum int { OP_ZERO, OP_SUB, OP_NORMAL, OP_INF, OP_QNAN, OP_SNAN, OP_BITS } op_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t data_i = '0;
  logic busy;
  logic done_o;
  res_t result_o;

  req_t pending_q[$];
  res_t hypot_q[$];
  int   idle_cnt = 0;
  int   stall_cnt = 0;
  int   errors = 0;

  binary128_hypot DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .data_i(data_i),
    .busy(busy), .done_o(done_o), .result_o(result_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int bit_len(logic [399:0] v);
    int i;
    for (i = 399; i >= 0; i--) begin
      if (v[i]) return i + 1;
    end
    return 0;
  endfunction

  function automatic logic is_signaling(logic [63:0] hi, logic [63:0] lo);
    return (hi > EXP_HI || (hi == EXP_HI && lo != 0)) && !(hi & QUIET_HI);
  endfunction

  function automatic res_t hypot_expect(req_t r);
    logic [63:0]  ph, pl, qh, ql, ah, al, bh, bl;
    logic [399:0] ma, mb, rad, root, remd, trial;
    logic [127:0] quo;
    logic         ge, guard, sticky;
    int           ea, eb, dn, len, k, i, n, e0, e, sh;
    res_t         o;
    ph = r.x_hi & SIGN_MASK; pl = r.x_lo;
    qh = r.y_hi & SIGN_MASK; ql = r.y_lo;
    ge = ph > qh || (ph == qh && pl >= ql);
    ah = ge ? ph : qh; al = ge ? pl : ql;
    bh = ge ? qh : ph; bl = ge ? ql : pl;
    if (ah >= EXP_HI) begin
      if (is_signaling(ah, al) || is_signaling(bh, bl)) o = {EXP_HI | QUIET_HI, 64'h0};
      else if ((ah == EXP_HI && al == 0) || (bh == EXP_HI && bl == 0)) o = {EXP_HI, 64'h0};
      else o = {ah, al};
      return o;
    end
    if (bh == 0 && bl == 0) return {ah, al};
    ea = ah[62:48] != 0 ? int'(ah[62:48]) - EXP_MAX : EXP_MIN;
    eb = bh[62:48] != 0 ? int'(bh[62:48]) - EXP_MAX : EXP_MIN;
    dn = ea - eb;
    if (dn > GAP_MAX) return {ah, al};
    ma = {287'b0, ah[62:48] != 0, ah[47:0], al};
    mb = {287'b0, bh[62:48] != 0, bh[47:0], bl};
    rad = ((ma * ma) << (2 * dn)) + mb * mb;
    len = bit_len(rad);
    k = len < ROOT_MIN ? (ROOT_MIN + 1 - len) / 2 : 0;
    rad = rad << (2 * k);
    root = '0; remd = '0;
    for (i = 191; i >= 0; i--) begin
      remd = (remd << 2) | rad[2*i +: 2];
      trial = (root << 2) | 400'd1;
      root = root << 1;
      if (remd >= trial) begin
        remd = remd - trial;
        root[0] = 1'b1;
      end
    end
    n = bit_len(root);
    e0 = eb - (SIG_BITS - 1) - k;
    e = e0 + n - 1;
    if (e > EXP_MAX) return {EXP_HI, 64'h0};
    sh = e >= EXP_MIN ? n - SIG_BITS : EXP_MIN - (SIG_BITS - 1) - e0;
    if (sh < 1) sh = 1;
    if (sh > 255) sh = 255;
    quo = 128'(root >> sh);
    guard = root[sh-1];
    sticky = remd != 0 || (root & ((400'd1 << (sh - 1)) - 400'd1)) != 0;
    if (guard && (sticky || quo[0])) quo = quo + 128'd1;
    if (e >= EXP_MIN) quo[127:64] = quo[127:64] + (64'(e - EXP_MIN) << 48);
    return quo;
  endfunction

  function automatic logic [127:0] make_op(op_kind_e kind, int ex);
    logic [63:0] hi, lo;
    hi = {$urandom, $urandom};
    lo = {$urandom, $urandom};
    case (kind)
      OP_ZERO: begin
        hi = hi & ~SIGN_MASK; lo = '0;
      end
      OP_SUB: begin
        hi = hi & ~64'h7fff000000000000;
      end
      OP_NORMAL: begin
        hi = (hi & ~64'h7fff000000000000) | (64'(ex) << 48);
      end
      OP_INF: begin
        hi = (hi & ~SIGN_MASK) | EXP_HI; lo = '0;
      end
      OP_QNAN: begin
        hi = hi | EXP_HI | QUIET_HI;
      end
      OP_SNAN: begin
        hi = (hi | EXP_HI) & ~QUIET_HI;
        if ((hi & FRAC_MASK) == 0 && lo == 0) lo = 64'h1;
      end
      default: ;
    endcase
    return {hi, lo};
  endfunction

  function automatic op_kind_e kind_from(int sel);
    case (sel)
      0: return OP_ZERO;
      1: return OP_SUB;
      2: return OP_INF;
      3: return OP_QNAN;
      4: return OP_SNAN;
      default: return OP_BITS;
    endcase
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      idle_cnt <= 0;
    end else begin
      if (start && !busy) hypot_q.push_back(hypot_expect(data_i));
      if (!start || !busy) begin
        if (idle_cnt > 0) begin
          start <= 1'b0;
          idle_cnt <= idle_cnt - 1;
        end else if (pending_q.size() > QUIET_TAIL && $urandom_range(3) == 0) begin
          start <= 1'b0;
          idle_cnt <= $urandom_range(0, 18);
        end else if (pending_q.size() > 0) begin
          start <= 1'b1;
          data_i <= pending_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (hypot_q.size() == 0) begin
          report("unexpected result_hi", result_o.result_hi, 64'h0);
        end else begin
          if (result_o.result_hi !== hypot_q[0].result_hi)
            report("result_hi", result_o.result_hi, hypot_q[0].result_hi);
          if (result_o.result_lo !== hypot_q[0].result_lo)
            report("result_lo", result_o.result_lo, hypot_q[0].result_lo);
          void'(hypot_q.pop_front());
        end
      end
      if (done_o || (start && !busy)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_MAX) begin
        $display("binary128_hypot test failed");
        $finish;
      end
    end
  end

  initial begin
    int i, ex, ey, gap;
    logic [127:0] a, b;
    // extremes and special operands
    pending_q.push_back('0);
    pending_q.push_back({64'h8000000000000000, 64'h0, 64'h8000000000000000, 64'h0});
    pending_q.push_back({64'h7ffeffffffffffff, 64'hffffffffffffffff,
                         64'h7ffeffffffffffff, 64'hffffffffffffffff});
    pending_q.push_back({64'h0, 64'h1, 64'h0, 64'h1});
    pending_q.push_back({64'h0, 64'h1, 64'h0, 64'h0});
    pending_q.push_back({64'h0000ffffffffffff, 64'hffffffffffffffff,
                         64'h8000ffffffffffff, 64'hffffffffffffffff});
    pending_q.push_back({64'h3fff000000000000, 64'h0, 64'hbfff000000000000, 64'h0});
    pending_q.push_back({64'h4000800000000000, 64'h0, 64'h4001000000000000, 64'h0});
    pending_q.push_back({64'h4038000000000000, 64'h0, 64'h3fff000000000000, 64'h0});
    pending_q.push_back({64'h4039000000000000, 64'h0, 64'hbfffffffffffffff, 64'hffffffffffffffff});
    pending_q.push_back({64'h7fff000000000000, 64'h0, 64'h3fff000000000000, 64'h0});
    pending_q.push_back({64'h7fff000000000000, 64'h0, 64'h7fff800000000000, 64'h5});
    pending_q.push_back({64'hffff800000001234, 64'h0, 64'h3fff000000000000, 64'h0});
    pending_q.push_back({64'h7fff000000000000, 64'h1, 64'h7fff000000000000, 64'h0});
    pending_q.push_back({64'h7fff800000000000, 64'h0, 64'hffff400000000000, 64'h0});
    pending_q.push_back({64'hffffffffffffffff, 64'hffffffffffffffff, 64'h0, 64'h0});
    pending_q.push_back({64'h7ffeffffffffffff, 64'hffffffffffffffff, 64'h0, 64'h0});
    pending_q.push_back({64'h0001000000000000, 64'h0, 64'h0000ffffffffffff, 64'hffffffffffffffff});
    pending_q.push_back({64'h0000000000000000, 64'h3, 64'h0, 64'h4});
    pending_q.push_back({64'h7ffe000000000000, 64'h0, 64'h7ffe000000000000, 64'h0});
    for (i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(9) < 7) begin
        case ($urandom_range(3))
          0: ex = $urandom_range(1, 80);
          1: ex = $urandom_range(32686, 32766);
          default: ex = $urandom_range(1, 32766);
        endcase
        gap = $urandom_range(3) == 0 ? $urandom_range(0, 70) : $urandom_range(0, 3);
        ey = ex - gap;
        a = make_op(OP_NORMAL, ex);
        b = ey >= 1 ? make_op(OP_NORMAL, ey) : make_op(OP_SUB, 0);
      end else begin
        a = make_op(kind_from($urandom_range(0, 9)), 0);
        b = make_op(kind_from($urandom_range(0, 9)), 0);
      end
      if ($urandom_range(1)) pending_q.push_back({a, b});
      else pending_q.push_back({b, a});
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(pending_q.size() == 0 && !start && hypot_q.size() == 0)) @(posedge clk_i);
    repeat (900) @(posedge clk_i);
    if (errors == 0) begin
      $display("binary128_hypot test passed");
    end else begin
      $display("binary128_hypot test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
